// ===== rtl/core/spi_sbe_pkg.sv =====
// shared types and constants of the spi slave burst exchange block
// no dependencies; used by the store, the fsm and the top level
package spi_sbe_pkg;

   localparam int BURST_BYTES_DEF = 100;

   localparam int BUDGET_W = 20;
   localparam int INDEX_W  = 7;
   localparam int BYTE_W   = 8;
   localparam int LENGTH_W = 16;

   localparam logic [BUDGET_W-1:0] BUDGET_RESET = 20'd100000;

   localparam logic KIND_SAMPLE = 1'b0;
   localparam logic KIND_STORE  = 1'b1;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_RECV = 4'b0010,
      PH_WAIT = 4'b0100,
      PH_SEND = 4'b1000
   } phase_type;

   typedef struct packed {
      logic               kind;
      logic               chip_select_n;
      logic               serial_clock;
      logic               master_out;
      logic [INDEX_W-1:0] store_index;
      logic [BYTE_W-1:0]  store_value;
   } req_item_type;

   typedef struct packed {
      logic               slave_out;
      logic               byte_valid;
      logic [BYTE_W-1:0]  byte_value;
      logic [INDEX_W-1:0] byte_position;
      logic               frame_done;
      logic [INDEX_W-1:0] payload_length;
      logic               timed_out;
      logic               busy_res;
   } rsp_item_type;

   typedef logic [BUDGET_W-1:0] csr_item_type;

endpackage

// ===== rtl/core/spi_sbe_chan_if.sv =====
// valid/ready channel carrying one item of any payload type
// depends on nothing; payload types come from spi_sbe_pkg at instantiation
interface spi_sbe_chan_if #(parameter type item_type = logic);
   logic     valid;
   logic     ready;
   item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/spi_sbe_store.sv =====
// transmit store: one write port, one registered read port, zero sweep after reset
// depends on spi_sbe_pkg
module spi_sbe_store #(
   parameter int BURST_BYTES = spi_sbe_pkg::BURST_BYTES_DEF,
   parameter int ADDR_W      = $clog2(BURST_BYTES)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [spi_sbe_pkg::BYTE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [spi_sbe_pkg::BYTE_W-1:0] rd_data,
   output logic                           clearing
);
   import spi_sbe_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(BURST_BYTES - 1);

   logic [BYTE_W-1:0] mem [BURST_BYTES];
   logic              clear_ff;
   logic              clear_in;
   logic [ADDR_W-1:0] clear_addr_ff;
   logic [ADDR_W-1:0] clear_addr_in;
   logic [BYTE_W-1:0] rd_data_ff;

   always_comb begin
      clear_in      = clear_ff;
      clear_addr_in = clear_addr_ff;
      if (clear_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_ADDR) begin
            clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clear_ff      <= clear_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         mem[clear_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data  = rd_data_ff;
   assign clearing = clear_ff;

endmodule

// ===== rtl/core/spi_sbe_fsm.sv =====
// frame state machine: edge detect, receive shifter, budget, transmit sequencing
// depends on spi_sbe_pkg; reads the transmit store through spi_sbe_store
module spi_sbe_fsm #(
   parameter int BURST_BYTES = spi_sbe_pkg::BURST_BYTES_DEF,
   parameter int ADDR_W      = $clog2(BURST_BYTES)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  spi_sbe_pkg::req_item_type        item,
   input  logic [spi_sbe_pkg::BUDGET_W-1:0] sample_budget,
   output spi_sbe_pkg::rsp_item_type        result,
   output logic                             wr_en,
   output logic [ADDR_W-1:0]                wr_addr,
   output logic [spi_sbe_pkg::BYTE_W-1:0]   wr_data,
   output logic [ADDR_W-1:0]                rd_addr,
   input  logic [spi_sbe_pkg::BYTE_W-1:0]   rd_data
);
   import spi_sbe_pkg::*;

   localparam int CNT_W = $clog2(BURST_BYTES + 1);
   localparam logic [CNT_W-1:0] BURST_CNT = CNT_W'(BURST_BYTES);

   phase_type           phase_ff, phase_in;
   logic                last_clock_ff, last_clock_in;
   logic                last_select_ff, last_select_in;
   logic [2:0]          bit_cnt_ff, bit_cnt_in;
   logic [CNT_W-1:0]    byte_cnt_ff, byte_cnt_in;
   logic [BYTE_W-1:0]   shift_ff, shift_in;
   logic [BUDGET_W-1:0] budget_ff, budget_in;
   logic [LENGTH_W-1:0] length_ff, length_in;
   logic                miso_ff, miso_in;
   logic [BYTE_W-1:0]   cur_byte_ff, cur_byte_in;

   logic                clk_rise;
   logic                cs_rise;
   logic [BYTE_W-1:0]   shift_next;
   logic [CNT_W-1:0]    byte_next;
   logic [2:0]          bit_sel;

   assign clk_rise   = item.serial_clock & ~last_clock_ff;
   assign cs_rise    = item.chip_select_n & ~last_select_ff;
   assign shift_next = {shift_ff[BYTE_W-2:0], item.master_out};
   assign byte_next  = byte_cnt_ff + 1'b1;
   assign bit_sel    = 3'd6 - bit_cnt_ff;

   // prefetch of the next byte to send, byte 0 outside the send phase
   assign rd_addr = (phase_ff == PH_SEND && byte_next < BURST_CNT) ?
                    byte_next[ADDR_W-1:0] : '0;

   assign wr_addr = ADDR_W'(item.store_index);
   assign wr_data = item.store_value;

   always_comb begin
      phase_in       = phase_ff;
      last_clock_in  = last_clock_ff;
      last_select_in = last_select_ff;
      bit_cnt_in     = bit_cnt_ff;
      byte_cnt_in    = byte_cnt_ff;
      shift_in       = shift_ff;
      budget_in      = budget_ff;
      length_in      = length_ff;
      miso_in        = miso_ff;
      cur_byte_in    = cur_byte_ff;
      wr_en          = 1'b0;
      result         = '0;

      if (item.kind == KIND_STORE) begin
         if (phase_ff == PH_IDLE && 32'(item.store_index) < 32'(BURST_BYTES)) begin
            wr_en = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               if (!item.chip_select_n && last_select_ff) begin
                  phase_in       = PH_RECV;
                  budget_in      = sample_budget;
                  last_clock_in  = 1'b0;
                  last_select_in = 1'b0;
                  bit_cnt_in     = '0;
                  byte_cnt_in    = '0;
                  shift_in       = '0;
               end else begin
                  last_select_in = item.chip_select_n;
               end
            end
            default: begin
               if (budget_ff == '0) begin
                  result.timed_out = 1'b1;
                  miso_in          = 1'b0;
                  phase_in         = PH_IDLE;
                  last_select_in   = item.chip_select_n;
               end else begin
                  budget_in      = budget_ff - 1'b1;
                  last_clock_in  = item.serial_clock;
                  last_select_in = item.chip_select_n;
                  if (phase_ff == PH_RECV && clk_rise) begin
                     shift_in = shift_next;
                     if (bit_cnt_ff == 3'd7) begin
                        bit_cnt_in           = '0;
                        result.byte_valid    = 1'b1;
                        result.byte_value    = shift_next;
                        result.byte_position = INDEX_W'(byte_cnt_ff);
                        if (byte_cnt_ff == '0) begin
                           length_in[7:0] = shift_next;
                        end else if (byte_cnt_ff == CNT_W'(1)) begin
                           length_in[15:8] = shift_next;
                        end
                        byte_cnt_in = byte_next;
                        if (byte_next >= BURST_CNT) begin
                           phase_in = PH_WAIT;
                        end
                     end else begin
                        bit_cnt_in = bit_cnt_ff + 1'b1;
                     end
                  end else if (phase_ff == PH_WAIT && cs_rise) begin
                     phase_in    = PH_SEND;
                     bit_cnt_in  = '0;
                     byte_cnt_in = '0;
                     miso_in     = rd_data[7];
                     cur_byte_in = rd_data;
                  end else if (phase_ff == PH_SEND && clk_rise) begin
                     if (bit_cnt_ff != 3'd7) begin
                        bit_cnt_in = bit_cnt_ff + 1'b1;
                        miso_in    = cur_byte_ff[bit_sel];
                     end else begin
                        bit_cnt_in  = '0;
                        byte_cnt_in = byte_next;
                        if (byte_next >= BURST_CNT) begin
                           result.frame_done = 1'b1;
                           if (32'(length_ff) > 32'(BURST_BYTES - 2)) begin
                              result.payload_length = '0;
                           end else begin
                              result.payload_length = length_ff[INDEX_W-1:0];
                           end
                           miso_in  = 1'b0;
                           phase_in = PH_IDLE;
                        end else begin
                           miso_in     = rd_data[7];
                           cur_byte_in = rd_data;
                        end
                     end
                  end
               end
            end
         endcase
      end

      result.slave_out = miso_in;
      result.busy_res  = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         last_clock_ff  <= 1'b0;
         last_select_ff <= 1'b1;
         bit_cnt_ff     <= '0;
         byte_cnt_ff    <= '0;
         shift_ff       <= '0;
         budget_ff      <= '0;
         length_ff      <= '0;
         miso_ff        <= 1'b0;
         cur_byte_ff    <= '0;
      end else if (step) begin
         phase_ff       <= phase_in;
         last_clock_ff  <= last_clock_in;
         last_select_ff <= last_select_in;
         bit_cnt_ff     <= bit_cnt_in;
         byte_cnt_ff    <= byte_cnt_in;
         shift_ff       <= shift_in;
         budget_ff      <= budget_in;
         length_ff      <= length_in;
         miso_ff        <= miso_in;
         cur_byte_ff    <= cur_byte_in;
      end
   end

endmodule

// ===== rtl/core/spi_slave_burst_exchange_top.sv =====
// top level of the spi slave burst exchange: input, result and budget registers
// depends on spi_sbe_pkg, spi_sbe_chan_if, spi_sbe_store and spi_sbe_fsm
//
// usage:
//   req_if carries one item per pin sample (kind 0) or one transmit store write
//   (kind 1, taken only between frames). rsp_if returns exactly one item for
//   each req_if item, in order: miso level, received byte with its position,
//   frame end with the header length, timeout flag and busy.
//   csr_if writes the 20-bit sample budget; write it only while no frame runs
//   and no item is in flight. It is always ready.
// timing:
//   an item is registered in the input register at acceptance and processed
//   from there; its result goes to the result register when the output can
//   advance and is offered from there. One item is accepted every cycle while
//   rsp_if is not stalled and no store sweep runs; the transmit store is read
//   one byte ahead through its registered read port, so no sample waits on it.
// reset:
//   synchronous; afterwards the transmit store is swept to zero, one byte a
//   cycle over all BURST_BYTES entries, and req_if stays not ready meanwhile.
// backpressure:
//   while rsp_if is stalled the result register holds, the input register
//   holds one more item, and then req_if deasserts ready.
module spi_slave_burst_exchange_top #(
   parameter int BURST_BYTES = spi_sbe_pkg::BURST_BYTES_DEF
) (
   input logic           clock,
   input logic           reset,
   spi_sbe_chan_if.sink   req_if,
   spi_sbe_chan_if.source rsp_if,
   spi_sbe_chan_if.sink   csr_if
);
   import spi_sbe_pkg::*;

   localparam int ADDR_W = $clog2(BURST_BYTES);

   logic                in_valid_ff, in_valid_in;
   req_item_type        in_item_ff;
   logic                out_valid_ff, out_valid_in;
   rsp_item_type        out_item_ff;
   logic [BUDGET_W-1:0] budget_ff;

   logic                advance;
   logic                step;
   logic                clearing;
   rsp_item_type        result;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [BYTE_W-1:0]   wr_data;
   logic [ADDR_W-1:0]   rd_addr;
   logic [BYTE_W-1:0]   rd_data;

   assign advance      = ~out_valid_ff | rsp_if.ready;
   assign step         = in_valid_ff & advance;
   assign req_if.ready = ~clearing & (~in_valid_ff | advance);
   assign in_valid_in  = (req_if.valid & req_if.ready) | (in_valid_ff & ~advance);
   assign out_valid_in = step | (out_valid_ff & ~rsp_if.ready);
   assign csr_if.ready = 1'b1;

   assign rsp_if.valid = out_valid_ff;
   assign rsp_if.data  = out_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         budget_ff    <= BUDGET_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_if.valid) begin
            budget_ff <= csr_if.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_item_ff <= req_if.data;
      end
      if (step) begin
         out_item_ff <= result;
      end
   end

   spi_sbe_fsm #(
      .BURST_BYTES (BURST_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_fsm (
      .clock         (clock),
      .reset         (reset),
      .step          (step),
      .item          (in_item_ff),
      .sample_budget (budget_ff),
      .result        (result),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data)
   );

   spi_sbe_store #(
      .BURST_BYTES (BURST_BYTES),
      .ADDR_W      (ADDR_W)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en & step),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .clearing (clearing)
   );

endmodule
